// File: rtl/command_line_argument_splitter_macros.svh
// Assertion macros used by the checker of the argument splitter.
// Depends on nothing; clock and reset are taken from the including scope.
`ifndef COMMAND_LINE_ARGUMENT_SPLITTER_MACROS_SVH
`define COMMAND_LINE_ARGUMENT_SPLITTER_MACROS_SVH

// Same-cycle implication, off during reset.
`define CLAS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("splitter check failed");

// Next-cycle implication, off during reset.
`define CLAS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("splitter check failed");

`endif

// File: rtl/clas_pkg.sv
// Types, codes and tables for the command line argument splitter.
// No dependencies.
`timescale 1ns / 1ps

package clas_pkg;

   localparam int RunBitsDefault = 16;

   localparam logic [2:0] KIND_TEXT      = 3'd0;
   localparam logic [2:0] KIND_ARG_END   = 3'd1;
   localparam logic [2:0] KIND_DONE      = 3'd2;
   localparam logic [2:0] KIND_BAD_QUOTE = 3'd3;
   localparam logic [2:0] KIND_META      = 3'd4;

   localparam logic ACTION_CHAR = 1'b0;
   localparam logic ACTION_END  = 1'b1;

   localparam logic [15:0] CH_BSLASH = 16'h005C;
   localparam logic [15:0] CH_QUOTE  = 16'h0022;
   localparam logic [15:0] CH_SPACE  = 16'h0020;
   localparam logic [15:0] CH_TAB    = 16'h0009;

   // bit c set for shell meta characters & ( ) < > @ ^ |
   localparam logic [127:0] META_MAP =
      128'h10000000_40000001_50000340_00000000;

   typedef struct packed {
      logic        action;
      logic [15:0] char_code;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] backslash_run;
      logic        has_char;
      logic [15:0] char_value;
   } rsp_type;

   function automatic logic is_meta(input logic [15:0] c);
      return (c[15:7] == 9'd0) && META_MAP[c[6:0]];
   endfunction

   function automatic logic is_space(input logic [15:0] c);
      return (c == CH_SPACE) || (c == CH_TAB);
   endfunction

   // clamp a run count of up to 33 bits to the 16-bit field
   function automatic logic [15:0] clamp_run(input logic [32:0] run);
      return (run > 33'h0FFFF) ? 16'hFFFF : run[15:0];
   endfunction

   function automatic rsp_type make_rsp(input logic [2:0] kind, input logic [15:0] run,
                                        input logic has, input logic [15:0] ch);
      rsp_type r;
      r.kind          = kind;
      r.backslash_run = run;
      r.has_char      = has;
      r.char_value    = ch;
      return r;
   endfunction

endpackage

// File: rtl/command_line_argument_splitter.sv
// Windows-rule command line splitter, one 16-bit character per transfer.
// Items pass the input register, then the result queue; an end item closing an open
// argument gives two results. Throughput: one item per cycle while the queue has room.
// Result queue: 4 entries; req_ready drops while s1 is full and under 2 are free.
// Reset (synchronous, active high) clears parse state, abort_ff and both stages.
`timescale 1ns / 1ps

module command_line_argument_splitter
   import clas_pkg::*;
#(
   parameter int RUN_BITS = RunBitsDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   localparam logic [RUN_BITS-1:0] RunMax = '1;

   // input register
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_item_ff;
   logic    s1_adv;

   // parse state
   logic                in_arg_ff, in_arg_in;
   logic                in_quote_ff, in_quote_in;
   logic                close_pend_ff, close_pend_in;
   logic                failed_ff, failed_in;
   logic [RUN_BITS-1:0] bs_count_ff, bs_count_in;
   logic                abort_ff;

   // results of the current item
   logic [1:0] n_res;
   rsp_type    res0, res1;
   logic [15:0] run_full, run_half;
   logic        quote_open;
   logic [15:0] c;

   // result queue
   rsp_type    q_ff [4];
   logic [1:0] wr_ptr_ff, rd_ptr_ff;
   logic [2:0] q_count_ff;
   logic       pop;

   assign csr_ready = 1'b1;

   assign s1_adv      = s1_valid_ff && (q_count_ff <= 3'd2);
   assign req_ready   = !s1_valid_ff || s1_adv;
   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !s1_adv);

   assign run_full = clamp_run(33'(bs_count_ff));
   assign run_half = clamp_run(33'(bs_count_ff >> 1));
   assign c        = s1_item_ff.char_code;
   // a quote pending close counts as closed
   assign quote_open = in_quote_ff && !close_pend_ff;

   always_comb begin
      in_arg_in     = in_arg_ff;
      in_quote_in   = in_quote_ff;
      close_pend_in = close_pend_ff;
      failed_in     = failed_ff;
      bs_count_in   = bs_count_ff;
      n_res         = 2'd0;
      res0          = make_rsp(KIND_DONE, 16'd0, 1'b0, 16'd0);
      res1          = make_rsp(KIND_DONE, 16'd0, 1'b0, 16'd0);
      if (s1_item_ff.action == ACTION_END) begin
         if (!failed_ff) begin
            priority if (quote_open) begin
               res0  = make_rsp(KIND_BAD_QUOTE, 16'd0, 1'b0, 16'd0);
               n_res = 2'd1;
            end else if (in_arg_ff) begin
               res0  = make_rsp(KIND_ARG_END, run_full, 1'b0, 16'd0);
               n_res = 2'd2;
            end else begin
               n_res = 2'd1;
            end
         end
         in_arg_in     = 1'b0;
         in_quote_in   = 1'b0;
         close_pend_in = 1'b0;
         failed_in     = 1'b0;
         bs_count_in   = '0;
      end else if (!failed_ff) begin
         close_pend_in = 1'b0;
         in_quote_in   = quote_open;
         priority if (close_pend_ff && c == CH_QUOTE) begin
            // second quote of a pair inside quotes
            res0  = make_rsp(KIND_TEXT, 16'd0, 1'b1, CH_QUOTE);
            n_res = 2'd1;
         end else if (c == CH_BSLASH) begin
            in_arg_in = 1'b1;
            if (bs_count_ff != RunMax) begin
               bs_count_in = bs_count_ff + RUN_BITS'(1);
            end
         end else if (c == CH_QUOTE) begin
            in_arg_in   = 1'b1;
            bs_count_in = '0;
            priority if (bs_count_ff[0]) begin
               res0  = make_rsp(KIND_TEXT, run_half, 1'b1, CH_QUOTE);
               n_res = 2'd1;
            end else begin
               if (run_half != 16'd0) begin
                  res0  = make_rsp(KIND_TEXT, run_half, 1'b0, 16'd0);
                  n_res = 2'd1;
               end
               if (quote_open) begin
                  close_pend_in = 1'b1;
               end else begin
                  in_quote_in = 1'b1;
               end
            end
         end else if (!quote_open && is_space(c)) begin
            if (in_arg_ff) begin
               res0  = make_rsp(KIND_ARG_END, run_full, 1'b0, 16'd0);
               n_res = 2'd1;
            end
            in_arg_in   = 1'b0;
            bs_count_in = '0;
         end else if (!quote_open && abort_ff && is_meta(c)) begin
            in_arg_in = 1'b1;
            failed_in = 1'b1;
            res0      = make_rsp(KIND_META, 16'd0, 1'b0, 16'd0);
            n_res     = 2'd1;
         end else begin
            in_arg_in   = 1'b1;
            bs_count_in = '0;
            res0        = make_rsp(KIND_TEXT, run_full, 1'b1, c);
            n_res       = 2'd1;
         end
      end
   end

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (q_count_ff != 3'd0);
   assign rsp_data  = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         in_arg_ff     <= 1'b0;
         in_quote_ff   <= 1'b0;
         close_pend_ff <= 1'b0;
         failed_ff     <= 1'b0;
         bs_count_ff   <= '0;
         abort_ff      <= 1'b0;
         wr_ptr_ff     <= 2'd0;
         rd_ptr_ff     <= 2'd0;
         q_count_ff    <= 3'd0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (csr_valid && csr_ready) begin
            abort_ff <= csr_data;
         end
         if (s1_adv) begin
            in_arg_ff     <= in_arg_in;
            in_quote_ff   <= in_quote_in;
            close_pend_ff <= close_pend_in;
            failed_ff     <= failed_in;
            bs_count_ff   <= bs_count_in;
            wr_ptr_ff     <= wr_ptr_ff + n_res;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         q_count_ff <= q_count_ff + (s1_adv ? 3'(n_res) : 3'd0) - 3'(pop);
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff <= req_data;
      end
      if (s1_adv && n_res != 2'd0) begin
         q_ff[wr_ptr_ff] <= res0;
      end
      if (s1_adv && n_res == 2'd2) begin
         q_ff[wr_ptr_ff + 2'd1] <= res1;
      end
   end

endmodule

// File: rtl/clas_checker.sv
// Port-level checks of the argument splitter's result channel, bound to the top level.
// Depends on clas_pkg and command_line_argument_splitter_macros.svh.
`timescale 1ns / 1ps
`include "command_line_argument_splitter_macros.svh"

module clas_checker
   import clas_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   logic bare_kind;
   logic bare_payload;

   assign bare_kind    = (rsp_data.kind == KIND_DONE) || (rsp_data.kind == KIND_BAD_QUOTE)
                         || (rsp_data.kind == KIND_META);
   assign bare_payload = (rsp_data.backslash_run == 16'd0) && !rsp_data.has_char;

   // hold a stalled transfer
   `CLAS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `CLAS_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_data))
   `CLAS_ASSERT_NOW(a_kind_range, rsp_valid, rsp_data.kind <= KIND_META)
   `CLAS_ASSERT_NOW(a_no_char_zero, rsp_valid && !rsp_data.has_char, rsp_data.char_value == 16'd0)
   // list complete and errors carry no run and no character
   `CLAS_ASSERT_NOW(a_bare_kinds, rsp_valid && bare_kind, bare_payload)

endmodule

bind command_line_argument_splitter clas_checker u_clas_checker (.*);

// File: tb/sv/tb_command_line_argument_splitter.sv
// Self-checking testbench for command_line_argument_splitter: directed and random command lines.
// Depends on clas_pkg and the splitter RTL; predicts every result and compares it on transfer.
`timescale 1ns / 1ps

module tb_command_line_argument_splitter;
   import clas_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 1200;
   localparam int unsigned STALL_LIMIT  = 1000;
   localparam int unsigned MAX_GAP      = 12;
   localparam int unsigned PRINT_LIMIT  = 30;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_data;

   command_line_argument_splitter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // predicted parse state and register
   logic        meta_abort;
   logic        arg_open;
   logic        quoting;
   logic        quote_closing;
   logic [15:0] slash_run;
   logic        parse_failed;

   rsp_type     pending_pieces[$];

   int unsigned items_accepted;
   int unsigned pieces_checked;
   int unsigned reg_writes;
   int unsigned error_count;
   int unsigned idle_cycles;
   logic        send_gaps_on;
   logic        rsp_gaps_on;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic is_shell_meta(input logic [15:0] c);
      case (c)
         16'h0026, 16'h0028, 16'h0029, 16'h003C,
         16'h003E, 16'h0040, 16'h005E, 16'h007C: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic void queue_piece(input logic [2:0] kind, input logic [15:0] run,
                                       input logic has, input logic [15:0] ch);
      rsp_type p;
      p.kind          = kind;
      p.backslash_run = run;
      p.has_char      = has;
      p.char_value    = ch;
      pending_pieces.push_back(p);
   endfunction

   function automatic void clear_split_state();
      arg_open      = 1'b0;
      quoting       = 1'b0;
      quote_closing = 1'b0;
      slash_run     = '0;
      parse_failed  = 1'b0;
   endfunction

   // Advance the split state by one accepted item and queue the pieces it yields.
   function automatic void predict_split(input req_type r);
      logic [15:0] c;
      c = r.char_code;
      if (r.action == ACTION_END) begin
         if (!parse_failed) begin
            if (quote_closing) begin
               quote_closing = 1'b0;
               quoting       = 1'b0;
            end
            if (quoting) begin
               queue_piece(KIND_BAD_QUOTE, '0, 1'b0, '0);
            end else begin
               if (arg_open) queue_piece(KIND_ARG_END, slash_run, 1'b0, '0);
               queue_piece(KIND_DONE, '0, 1'b0, '0);
            end
         end
         clear_split_state();
         return;
      end
      if (parse_failed) return;
      // a quote right after a closing quote is a literal quote
      if (quote_closing) begin
         quote_closing = 1'b0;
         quoting       = 1'b0;
         if (c == CH_QUOTE) begin
            queue_piece(KIND_TEXT, '0, 1'b1, CH_QUOTE);
            return;
         end
      end
      if (c == CH_BSLASH) begin
         arg_open = 1'b1;
         if (slash_run != 16'hFFFF) slash_run = slash_run + 16'd1;
         return;
      end
      if (c == CH_QUOTE) begin
         arg_open = 1'b1;
         if (slash_run[0]) begin
            queue_piece(KIND_TEXT, slash_run >> 1, 1'b1, CH_QUOTE);
            slash_run = '0;
            return;
         end
         if (slash_run != 16'd0) queue_piece(KIND_TEXT, slash_run >> 1, 1'b0, '0);
         slash_run = '0;
         if (quoting) quote_closing = 1'b1;
         else quoting = 1'b1;
         return;
      end
      if (!quoting && (c == CH_SPACE || c == CH_TAB)) begin
         if (arg_open) queue_piece(KIND_ARG_END, slash_run, 1'b0, '0);
         arg_open  = 1'b0;
         slash_run = '0;
         return;
      end
      arg_open = 1'b1;
      if (!quoting && meta_abort && is_shell_meta(c)) begin
         parse_failed = 1'b1;
         queue_piece(KIND_META, '0, 1'b0, '0);
         return;
      end
      queue_piece(KIND_TEXT, slash_run, 1'b1, c);
      slash_run = '0;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("%0t: result %0d %s: got %0h, want %0h",
                  $realtime, pieces_checked, what, got, want);
   endtask

   task automatic check_piece(input rsp_type got);
      rsp_type want;
      if (pending_pieces.size() == 0) begin
         report_mismatch("arrived with nothing pending", 32'(got.kind), 0);
      end else begin
         want = pending_pieces.pop_front();
         if (got.kind !== want.kind)
            report_mismatch("kind", 32'(got.kind), 32'(want.kind));
         if (got.backslash_run !== want.backslash_run)
            report_mismatch("backslash_run", 32'(got.backslash_run),
                            32'(want.backslash_run));
         if (got.has_char !== want.has_char)
            report_mismatch("has_char", 32'(got.has_char), 32'(want.has_char));
         if (got.char_value !== want.char_value)
            report_mismatch("char_value", 32'(got.char_value), 32'(want.char_value));
      end
      pieces_checked++;
   endtask

   // One process sees every transfer, so prediction and checking never race.
   always @(posedge clock) begin : monitor
      logic busy;
      busy = 1'b0;
      if (reset) begin
         meta_abort  = 1'b0;
         clear_split_state();
         idle_cycles = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            meta_abort = csr_data;
            reg_writes++;
            busy = 1'b1;
         end
         if (req_valid && req_ready) begin
            predict_split(req_data);
            items_accepted++;
            busy = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            check_piece(rsp_data);
            busy = 1'b1;
         end
         idle_cycles = busy ? 0 : idle_cycles + 1;
      end
   end

   // Receiver: draw a stall before each result transfer.
   initial begin : receiver
      int unsigned stall;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = rsp_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : watchdog
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("command_line_argument_splitter: mismatch");
      $finish;
   end

   // Valid stays high after a transfer; a gap or finish_burst lowers it.
   task automatic send_item(input logic act, input logic [15:0] code);
      int unsigned gap;
      gap = send_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data.action    <= act;
      req_data.char_code <= code;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(ACTION_CHAR, {8'h00, s[i]});
   endtask

   task automatic send_end();
      send_item(ACTION_END, 16'($urandom_range(0, 65535)));
   endtask

   task automatic finish_burst();
      req_valid <= 1'b0;
   endtask

   // Drain every pending result, then cover items still in flight without one.
   task automatic wait_quiet();
      @(posedge clock);
      while (pending_pieces.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_meta_abort(input logic v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] random_char();
      string       meta_set = "&()<>@^|";
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 30) return 16'h0061 + 16'($urandom_range(0, 25));
      if (sel < 40) return CH_SPACE;
      if (sel < 44) return CH_TAB;
      if (sel < 58) return CH_QUOTE;
      if (sel < 68) return CH_BSLASH;
      if (sel < 78) return {8'h00, meta_set[$urandom_range(0, 7)]};
      if (sel < 85) return 16'($urandom_range(16'h0021, 16'h007E));
      return 16'($urandom_range(0, 65535));
   endfunction

   // Separators, then field extremes of the character code.
   task automatic test_separators();
      send_text("a \t");
      send_item(ACTION_CHAR, 16'hFFFF);
      send_item(ACTION_CHAR, 16'h0000);
      send_end();
   endtask

   // Open, text, closing quote doubled into a literal, reopen, end inside quotes;
   // then an empty quoted argument closed by the end item.
   task automatic test_quoting();
      send_text("\"x\"\"\"");
      send_end();
      send_text("\"\"");
      send_end();
   endtask

   // Odd run before a quote, even run before a quote, trailing run at the end.
   task automatic test_backslashes();
      send_text("\\\\\\\"");
      send_text("\\\\\"a\"\\");
      send_end();
   endtask

   // Abort set: quoted meta passes, unquoted fails, later chars, end dropped; clear: meta passes.
   task automatic test_meta_abort();
      finish_burst();
      wait_quiet();
      write_meta_abort(1'b1);
      send_text("\"&\"|x");
      send_end();
      finish_burst();
      wait_quiet();
      write_meta_abort(1'b0);
      send_text("^");
      send_end();
   endtask

   // Long backslash runs before a quote and before a separator.
   task automatic test_long_runs();
      repeat (41) send_item(ACTION_CHAR, CH_BSLASH);
      send_item(ACTION_CHAR, CH_QUOTE);
      send_text("z");
      repeat (46) send_item(ACTION_CHAR, CH_BSLASH);
      send_item(ACTION_CHAR, CH_SPACE);
      send_end();
   endtask

   // Random command lines, each closed by an end item, with register changes between.
   task automatic test_random_lines();
      int unsigned start_count;
      int unsigned len;
      start_count = items_accepted;
      while (items_accepted - start_count < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) begin
            send_gaps_on = ($urandom_range(0, 3) != 0);
            rsp_gaps_on  = ($urandom_range(0, 3) != 0);
         end
         len = $urandom_range(0, 18);
         repeat (len) begin
            if ($urandom_range(0, 9) == 0)
               repeat ($urandom_range(1, 7)) send_item(ACTION_CHAR, CH_BSLASH);
            else
               send_item(ACTION_CHAR, random_char());
         end
         send_end();
         if ($urandom_range(0, 11) == 0) begin
            finish_burst();
            wait_quiet();
            write_meta_abort(1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_ready      = 1'b0;
      csr_valid      = 1'b0;
      csr_data       = 1'b0;
      items_accepted = 0;
      pieces_checked = 0;
      reg_writes     = 0;
      error_count    = 0;
      idle_cycles    = 0;
      send_gaps_on   = 1'b1;
      rsp_gaps_on    = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_meta_abort(1'b0);

      test_separators();
      test_quoting();
      test_backslashes();
      test_meta_abort();
      test_long_runs();
      test_random_lines();

      finish_burst();
      wait_quiet();
      repeat (8) @(posedge clock);

      $display("checked %0d results from %0d items across %0d register writes",
               pieces_checked, items_accepted, reg_writes);
      $display("covered separators, quoting, backslash runs, meta abort, random lines");
      if (error_count == 0) begin
         $display("command_line_argument_splitter: match");
      end else begin
         $display("%0d field errors", error_count);
         $display("command_line_argument_splitter: mismatch");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/clas_pkg.sv
rtl/command_line_argument_splitter.sv
rtl/clas_checker.sv
tb/sv/tb_command_line_argument_splitter.sv
